[rtl/rlw_pkg.sv]
// -----------------------------------------------------------------------------
// rlw_pkg
// Shared types and constants of the radial lens warp source address block.
// -----------------------------------------------------------------------------
package rlw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLE_RADIUS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;

    typedef logic [1:0] act_t;

    localparam act_t ACT_KEEP  = 2'd0;
    localparam act_t ACT_COPY  = 2'd1;
    localparam act_t ACT_BLACK = 2'd2;

    // Q.16 fractions in the ring reach 1.0 exactly, hence 17 bits.
    localparam int          Q16_W   = 17;
    localparam logic [16:0] Q16_ONE = 17'h10000;

    // Width of 84 * hole radius.
    localparam int TDEN_W = 23;
    // Magnitude of the Q.20 offset stays below 2^28.
    localparam int OFF_W  = 28;

    localparam logic [15:0] RESET_RADIUS   = 16'd256;
    localparam logic [15:0] RESET_STRENGTH = 16'd256;
    localparam logic [12:0] RESET_WIDTH    = 13'd1024;
    localparam logic [12:0] RESET_HEIGHT   = 13'd768;

endpackage

[rtl/rlw_isqrt.sv]
// -----------------------------------------------------------------------------
// rlw_isqrt
// Pipelined integer square root, one result bit per register stage.
// -----------------------------------------------------------------------------
module rlw_isqrt #(
    parameter int RAD_W  = 44,
    parameter int SIDE_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CAT_W  = ROOT_W + 4;

    logic [REM_W-1:0]  rem_s  [0:ROOT_W];
    logic [ROOT_W-1:0] root_s [0:ROOT_W];
    logic [RAD_W-1:0]  rad_s  [0:ROOT_W];
    logic [SIDE_W-1:0] side_s [0:ROOT_W];
    logic              vld_s  [0:ROOT_W];

    assign rem_s[0]  = '0;
    assign root_s[0] = '0;
    assign rad_s[0]  = radicand;
    assign side_s[0] = side_in;
    assign vld_s[0]  = in_valid;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic [CAT_W-1:0]  cat;
        logic [CAT_W-1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [REM_W-1:0]  rem_reg;
        logic [ROOT_W-1:0] root_reg;
        logic [RAD_W-1:0]  rad_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              vld_reg;

        always_comb
        begin
            cat      = {rem_s[i], rad_s[i][RAD_W-1 -: 2]};
            trial    = CAT_W'({root_s[i], 2'b01});
            take     = (cat >= trial);
            rem_next = take ? REM_W'(cat - trial) : REM_W'(cat);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= {root_s[i][ROOT_W-2:0], take};
                rad_reg  <= {rad_s[i][RAD_W-3:0], 2'b00};
                side_reg <= side_s[i];
            end
        end

        assign rem_s[i+1]  = rem_reg;
        assign root_s[i+1] = root_reg;
        assign rad_s[i+1]  = rad_reg;
        assign side_s[i+1] = side_reg;
        assign vld_s[i+1]  = vld_reg;
    end

    assign out_valid = vld_s[ROOT_W];
    assign root      = root_s[ROOT_W];
    assign side_out  = side_s[ROOT_W];

endmodule

[rtl/rlw_div.sv]
// -----------------------------------------------------------------------------
// rlw_div
// Pipelined restoring divider, one quotient bit per register stage. The upper
// dividend bits above the quotient must be below the divisor.
// -----------------------------------------------------------------------------
module rlw_div #(
    parameter int NUM_W  = 36,
    parameter int DEN_W  = 22,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [DEN_W-1:0]  rem_s  [0:Q_W];
    logic [Q_W-1:0]    low_s  [0:Q_W];
    logic [Q_W-1:0]    quo_s  [0:Q_W];
    logic [DEN_W-1:0]  den_s  [0:Q_W];
    logic [SIDE_W-1:0] side_s [0:Q_W];
    logic              vld_s  [0:Q_W];

    assign rem_s[0]  = DEN_W'(num[NUM_W-1:Q_W]);
    assign low_s[0]  = num[Q_W-1:0];
    assign quo_s[0]  = '0;
    assign den_s[0]  = den;
    assign side_s[0] = side_in;
    assign vld_s[0]  = in_valid;

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [DEN_W:0]    cat;
        logic              take;
        logic [DEN_W-1:0]  rem_next;
        logic [DEN_W-1:0]  rem_reg;
        logic [Q_W-1:0]    low_reg;
        logic [Q_W-1:0]    quo_reg;
        logic [DEN_W-1:0]  den_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              vld_reg;

        always_comb
        begin
            cat      = {rem_s[i], low_s[i][Q_W-1]};
            take     = (cat >= {1'b0, den_s[i]});
            rem_next = take ? DEN_W'(cat - {1'b0, den_s[i]}) : DEN_W'(cat);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                low_reg  <= {low_s[i][Q_W-2:0], 1'b0};
                quo_reg  <= {quo_s[i][Q_W-2:0], take};
                den_reg  <= den_s[i];
                side_reg <= side_s[i];
            end
        end

        assign rem_s[i+1]  = rem_reg;
        assign low_s[i+1]  = low_reg;
        assign quo_s[i+1]  = quo_reg;
        assign den_s[i+1]  = den_reg;
        assign side_s[i+1] = side_reg;
        assign vld_s[i+1]  = vld_reg;
    end

    assign out_valid = vld_s[Q_W];
    assign quo       = quo_s[Q_W];
    assign side_out  = side_s[Q_W];

endmodule

[rtl/radial_lens_warp_source_address.sv]
// -----------------------------------------------------------------------------
// radial_lens_warp_source_address
// Decides for each target pixel whether a radial lens warp keeps it, blacks it
// or copies it from a displaced, frame-clamped background source pixel.
// -----------------------------------------------------------------------------
// Usage: pixel coordinates enter as beats on the s_axis channel, one per
// clock when the output side keeps up. Each beat yields exactly one beat on
// m_axis carrying the action and the source coordinate, in input order.
// At the default width the pipeline has four setup stages, a 22-stage
// distance square root (one stage per root bit, one more for each coordinate
// bit above 12), a fade stage, a 17-stage divider, a saturation stage, a
// second square root of 17 stages, four multiply stages, a 28-stage offset
// divider and the output register. Lens registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no beat is in
// flight, which the block does not enforce. Reset clears the pipeline and
// sets the registers to centre 0, radius 16.0, strength 1.0 and a 1024 x 768
// frame. When the receiver stalls, one further result is held in a skid
// register and the pipeline holds with s_axis_tready low; nothing is lost.
// -----------------------------------------------------------------------------
module radial_lens_warp_source_address #(
    parameter int COORD_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rlw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pix_x, pix_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // action, src_x, src_y
    output logic [((2+2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CB      = COORD_BITS;
    localparam int OUT_TW  = ((2+2*CB+7)/8)*8;
    localparam int DW      = ((CB + 4 > 16) ? CB + 4 : 16) + 2;
    localparam int MW      = DW - 1;
    localparam int D2W     = 2 * DW;
    localparam int DTW     = DW + 4;
    localparam int LIM_W   = CB + 1;
    localparam int LW      = (LIM_W > 13) ? LIM_W : 13;
    localparam int NT_W    = DTW + 4;
    localparam int MAG_W   = MW + 32;
    localparam int SX_W    = CB + 2;
    localparam int QW      = rlw_pkg::Q16_W;
    localparam int OW      = rlw_pkg::OFF_W;
    localparam int TW      = rlw_pkg::TDEN_W;
    localparam int S1_W    = 2 + 2*CB + 2*DW;
    localparam int S2_W    = 2*QW + DTW + S1_W;
    localparam int SX_SIDE = 2 + CB + 1;
    localparam int SY_SIDE = CB + 1;
    localparam logic [LW-1:0] CMAX = LW'(1) << CB;

    // Configuration registers.
    logic signed [16:0] cx_reg;
    logic signed [16:0] cy_reg;
    logic [15:0]        r_reg;
    logic [15:0]        str_reg;
    logic [12:0]        fw_reg;
    logic [12:0]        fh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            r_reg   <= rlw_pkg::RESET_RADIUS;
            str_reg <= rlw_pkg::RESET_STRENGTH;
            fw_reg  <= rlw_pkg::RESET_WIDTH;
            fh_reg  <= rlw_pkg::RESET_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlw_pkg::CFG_CENTER_X:     cx_reg  <= signed'(cfg_data);
                rlw_pkg::CFG_CENTER_Y:     cy_reg  <= signed'(cfg_data);
                rlw_pkg::CFG_HOLE_RADIUS:  r_reg   <= cfg_data[15:0];
                rlw_pkg::CFG_STRENGTH:     str_reg <= cfg_data[15:0];
                rlw_pkg::CFG_FRAME_WIDTH:  fw_reg  <= cfg_data[12:0];
                rlw_pkg::CFG_FRAME_HEIGHT: fh_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic [LIM_W-1:0] limx;
    logic [LIM_W-1:0] limy;

    assign limx = (LW'(fw_reg) > CMAX) ? LIM_W'(CMAX) : LIM_W'(fw_reg);
    assign limy = (LW'(fh_reg) > CMAX) ? LIM_W'(CMAX) : LIM_W'(fh_reg);

    // Output buffer state; the pipeline moves whenever the skid is empty.
    logic              en;
    logic              out_valid_reg;
    logic [OUT_TW-1:0] out_data_reg;
    logic              skid_valid_reg;
    logic [OUT_TW-1:0] skid_data_reg;

    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;

    // Stage A: offsets from the centre.
    logic [CB-1:0]        pix_x;
    logic [CB-1:0]        pix_y;
    logic signed [DW-1:0] a_dx_next;
    logic signed [DW-1:0] a_dy_next;
    logic                 a_valid_reg;
    logic                 a_out_reg;
    logic [CB-1:0]        a_px_reg;
    logic [CB-1:0]        a_py_reg;
    logic signed [DW-1:0] a_dx_reg;
    logic signed [DW-1:0] a_dy_reg;

    assign pix_x     = s_axis_tdata[CB-1:0];
    assign pix_y     = s_axis_tdata[2*CB-1:CB];
    assign a_dx_next = $signed(DW'({pix_x, 4'b0000})) - DW'(cx_reg);
    assign a_dy_next = $signed(DW'({pix_y, 4'b0000})) - DW'(cy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_out_reg <= (LIM_W'(pix_x) >= limx) || (LIM_W'(pix_y) >= limy);
            a_px_reg  <= pix_x;
            a_py_reg  <= pix_y;
            a_dx_reg  <= a_dx_next;
            a_dy_reg  <= a_dy_next;
        end
    end

    // Stage B: squares.
    logic signed [D2W-1:0] sqx_w;
    logic signed [D2W-1:0] sqy_w;
    logic [31:0]           rr_w;
    logic                  b_valid_reg;
    logic                  b_out_reg;
    logic [D2W-1:0]        b_sqx_reg;
    logic [D2W-1:0]        b_sqy_reg;
    logic [31:0]           b_rr_reg;
    logic [CB-1:0]         b_px_reg;
    logic [CB-1:0]         b_py_reg;
    logic signed [DW-1:0]  b_dx_reg;
    logic signed [DW-1:0]  b_dy_reg;

    assign sqx_w = a_dx_reg * a_dx_reg;
    assign sqy_w = a_dy_reg * a_dy_reg;
    assign rr_w  = r_reg * r_reg;

    // Stage C: squared distance and ring bounds.
    logic [D2W-1:0]        d2_w;
    logic [37:0]           rr49_w;
    logic                  c_valid_reg;
    logic                  c_out_reg;
    logic [D2W-1:0]        c_d2_reg;
    logic [31:0]           c_rr_reg;
    logic [37:0]           c_rr49_reg;
    logic [CB-1:0]         c_px_reg;
    logic [CB-1:0]         c_py_reg;
    logic signed [DW-1:0]  c_dx_reg;
    logic signed [DW-1:0]  c_dy_reg;

    assign d2_w   = b_sqx_reg + b_sqy_reg;
    assign rr49_w = (38'(b_rr_reg) << 5) + (38'(b_rr_reg) << 4) + 38'(b_rr_reg);

    // Stage D: classification.
    rlw_pkg::act_t         act_w;
    logic                  d_valid_reg;
    rlw_pkg::act_t         d_act_reg;
    logic [D2W-1:0]        d_d2_reg;
    logic [CB-1:0]         d_px_reg;
    logic [CB-1:0]         d_py_reg;
    logic signed [DW-1:0]  d_dx_reg;
    logic signed [DW-1:0]  d_dy_reg;

    always_comb
    begin
        if (c_out_reg)
        begin
            act_w = rlw_pkg::ACT_KEEP;
        end
        else if (c_d2_reg < c_rr_reg)
        begin
            act_w = rlw_pkg::ACT_BLACK;
        end
        else if ({c_d2_reg, 2'b00} >= c_rr49_reg)
        begin
            act_w = rlw_pkg::ACT_KEEP;
        end
        else
        begin
            act_w = rlw_pkg::ACT_COPY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_out_reg  <= a_out_reg;
            b_sqx_reg  <= unsigned'(sqx_w);
            b_sqy_reg  <= unsigned'(sqy_w);
            b_rr_reg   <= rr_w;
            b_px_reg   <= a_px_reg;
            b_py_reg   <= a_py_reg;
            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            c_out_reg  <= b_out_reg;
            c_d2_reg   <= d2_w;
            c_rr_reg   <= b_rr_reg;
            c_rr49_reg <= rr49_w;
            c_px_reg   <= b_px_reg;
            c_py_reg   <= b_py_reg;
            c_dx_reg   <= b_dx_reg;
            c_dy_reg   <= b_dy_reg;
            d_act_reg  <= act_w;
            d_d2_reg   <= c_d2_reg;
            d_px_reg   <= c_px_reg;
            d_py_reg   <= c_py_reg;
            d_dx_reg   <= c_dx_reg;
            d_dy_reg   <= c_dy_reg;
        end
    end

    // Distance d in Q.8.
    logic                 s1_valid;
    logic [DTW-1:0]       s1_root;
    logic [S1_W-1:0]      s1_side;
    rlw_pkg::act_t        s1_act;
    logic [CB-1:0]        s1_px;
    logic [CB-1:0]        s1_py;
    logic [DW-1:0]        s1_dx;
    logic [DW-1:0]        s1_dy;

    rlw_isqrt #(
        .RAD_W  (2*DTW),
        .SIDE_W (S1_W)
    ) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid_reg),
        .radicand  ({d_d2_reg, 8'h00}),
        .side_in   ({d_act_reg, d_px_reg, d_py_reg, d_dx_reg, d_dy_reg}),
        .out_valid (s1_valid),
        .root      (s1_root),
        .side_out  (s1_side)
    );

    assign {s1_act, s1_px, s1_py, s1_dx, s1_dy} = s1_side;

    // Stage E: fade numerator and denominator.
    logic [NT_W-1:0]  d5_w;
    logic [NT_W-1:0]  r196_w;
    logic [NT_W-1:0]  numt_w;
    logic [TW-1:0]    r84_w;
    logic             e_valid_reg;
    logic [DTW-1:0]   e_d_reg;
    logic [TW-1:0]    e_numt_reg;
    logic [TW-1:0]    e_dent_reg;
    logic [S1_W-1:0]  e_side_reg;

    assign d5_w   = (NT_W'(s1_root) << 2) + NT_W'(s1_root);
    assign r196_w = (NT_W'(r_reg) << 7) + (NT_W'(r_reg) << 6) + (NT_W'(r_reg) << 2);
    assign numt_w = d5_w - r196_w;
    assign r84_w  = (TW'(r_reg) << 6) + (TW'(r_reg) << 4) + (TW'(r_reg) << 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_d_reg    <= s1_root;
            e_numt_reg <= numt_w[NT_W-1] ? '0 : numt_w[TW-1:0];
            e_dent_reg <= r84_w;
            e_side_reg <= {s1_act, s1_px, s1_py, s1_dx, s1_dy};
        end
    end

    // q = R / d and the fade fraction t, side by side.
    logic             q_valid;
    logic [QW-1:0]    q_quo;
    logic [S1_W-1:0]  q_side;
    logic             t_valid;
    logic [QW-1:0]    t_quo;
    logic [DTW-1:0]   t_side;

    rlw_div #(
        .NUM_W  (36),
        .DEN_W  (DTW),
        .Q_W    (QW),
        .SIDE_W (S1_W)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .num       ({r_reg, 20'h00000}),
        .den       (e_d_reg),
        .side_in   (e_side_reg),
        .out_valid (q_valid),
        .quo       (q_quo),
        .side_out  (q_side)
    );

    rlw_div #(
        .NUM_W  (TW + 16),
        .DEN_W  (TW),
        .Q_W    (QW),
        .SIDE_W (DTW)
    ) u_fade_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .num       ({e_numt_reg, 16'h0000}),
        .den       (e_dent_reg),
        .side_in   (e_d_reg),
        .out_valid (t_valid),
        .quo       (t_quo),
        .side_out  (t_side)
    );

    // Stage F: saturate q and t, form the fade.
    logic [QW-1:0]    t_cap_w;
    logic             f_valid_reg;
    logic [QW-1:0]    f_q_reg;
    logic [QW-1:0]    f_fade_reg;
    logic [DTW-1:0]   f_d_reg;
    logic [S1_W-1:0]  f_side_reg;

    assign t_cap_w = (t_quo > rlw_pkg::Q16_ONE) ? rlw_pkg::Q16_ONE : t_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= q_valid & t_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_q_reg    <= (q_quo > rlw_pkg::Q16_ONE) ? rlw_pkg::Q16_ONE : q_quo;
            f_fade_reg <= rlw_pkg::Q16_ONE - t_cap_w;
            f_d_reg    <= t_side;
            f_side_reg <= q_side;
        end
    end

    // s = sqrt(q) in Q.16.
    logic             s2_valid;
    logic [QW-1:0]    s2_root;
    logic [S2_W-1:0]  s2_side;
    logic [QW-1:0]    s2_fade;
    logic [DTW-1:0]   s2_d;
    logic [QW-1:0]    s2_q;
    logic [S1_W-1:0]  s2_rest;

    rlw_isqrt #(
        .RAD_W  (2*QW),
        .SIDE_W (S2_W)
    ) u_ratio_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .radicand  ({1'b0, f_q_reg, 16'h0000}),
        .side_in   ({f_fade_reg, f_d_reg, f_q_reg, f_side_reg}),
        .out_valid (s2_valid),
        .root      (s2_root),
        .side_out  (s2_side)
    );

    assign {s2_fade, s2_d, s2_q, s2_rest} = s2_side;

    // Stages G to J: power, fade, strength and the offset numerators.
    logic [2*QW-1:0]      pq_w;
    logic [2*QW-1:0]      pf_w;
    logic [32:0]          kf_w;
    logic                 g_valid_reg;
    logic [QW-1:0]        g_p_reg;
    logic [QW-1:0]        g_fade_reg;
    logic [DTW-1:0]       g_d_reg;
    logic [S1_W-1:0]      g_side_reg;
    logic                 h_valid_reg;
    logic [QW-1:0]        h_k_reg;
    logic [DTW-1:0]       h_d_reg;
    logic [S1_W-1:0]      h_side_reg;
    rlw_pkg::act_t        h_act;
    logic [CB-1:0]        h_px;
    logic [CB-1:0]        h_py;
    logic signed [DW-1:0] h_dx;
    logic signed [DW-1:0] h_dy;
    logic signed [DW-1:0] ndx_w;
    logic signed [DW-1:0] ndy_w;
    logic                 i_valid_reg;
    logic [31:0]          i_f_reg;
    logic [MW-1:0]        i_magx_reg;
    logic [MW-1:0]        i_magy_reg;
    logic                 i_negx_reg;
    logic                 i_negy_reg;
    logic [DTW-1:0]       i_d_reg;
    rlw_pkg::act_t        i_act_reg;
    logic [CB-1:0]        i_px_reg;
    logic [CB-1:0]        i_py_reg;
    logic                 j_valid_reg;
    logic [MAG_W-1:0]     j_mx_reg;
    logic [MAG_W-1:0]     j_my_reg;
    logic                 j_negx_reg;
    logic                 j_negy_reg;
    logic [DTW-1:0]       j_d_reg;
    rlw_pkg::act_t        j_act_reg;
    logic [CB-1:0]        j_px_reg;
    logic [CB-1:0]        j_py_reg;

    assign pq_w = s2_q * s2_root;
    assign pf_w = g_p_reg * g_fade_reg;
    assign kf_w = h_k_reg * str_reg;
    assign {h_act, h_px, h_py, h_dx, h_dy} = h_side_reg;
    assign ndx_w = -h_dx;
    assign ndy_w = -h_dy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= s2_valid;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_p_reg    <= pq_w[32:16];
            g_fade_reg <= s2_fade;
            g_d_reg    <= s2_d;
            g_side_reg <= s2_rest;
            h_k_reg    <= pf_w[32:16];
            h_d_reg    <= g_d_reg;
            h_side_reg <= g_side_reg;
            i_f_reg    <= kf_w[31:0];
            i_magx_reg <= h_dx[DW-1] ? ndx_w[MW-1:0] : h_dx[MW-1:0];
            i_magy_reg <= h_dy[DW-1] ? ndy_w[MW-1:0] : h_dy[MW-1:0];
            i_negx_reg <= h_dx[DW-1];
            i_negy_reg <= h_dy[DW-1];
            i_d_reg    <= h_d_reg;
            i_act_reg  <= h_act;
            i_px_reg   <= h_px;
            i_py_reg   <= h_py;
            j_mx_reg   <= i_magx_reg * i_f_reg;
            j_my_reg   <= i_magy_reg * i_f_reg;
            j_negx_reg <= i_negx_reg;
            j_negy_reg <= i_negy_reg;
            j_d_reg    <= i_d_reg;
            j_act_reg  <= i_act_reg;
            j_px_reg   <= i_px_reg;
            j_py_reg   <= i_py_reg;
        end
    end

    // Offsets in Q.20, magnitude divided by d.
    logic                 x_valid;
    logic [OW-1:0]        x_quo;
    logic [SX_SIDE-1:0]   x_side;
    logic                 y_valid;
    logic [OW-1:0]        y_quo;
    logic [SY_SIDE-1:0]   y_side;

    rlw_div #(
        .NUM_W  (MAG_W),
        .DEN_W  (DTW),
        .Q_W    (OW),
        .SIDE_W (SX_SIDE)
    ) u_offx_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (j_valid_reg),
        .num       (j_mx_reg),
        .den       (j_d_reg),
        .side_in   ({j_act_reg, j_px_reg, j_negx_reg}),
        .out_valid (x_valid),
        .quo       (x_quo),
        .side_out  (x_side)
    );

    rlw_div #(
        .NUM_W  (MAG_W),
        .DEN_W  (DTW),
        .Q_W    (OW),
        .SIDE_W (SY_SIDE)
    ) u_offy_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (j_valid_reg),
        .num       (j_my_reg),
        .den       (j_d_reg),
        .side_in   ({j_py_reg, j_negy_reg}),
        .out_valid (y_valid),
        .quo       (y_quo),
        .side_out  (y_side)
    );

    // Final: source position, clamped to the frame.
    rlw_pkg::act_t          k_act;
    logic [CB-1:0]          k_px;
    logic [CB-1:0]          k_py;
    logic                   k_negx;
    logic                   k_negy;
    logic signed [OW:0]     offx_w;
    logic signed [OW:0]     offy_w;
    logic signed [OW-20:0]  wholex_w;
    logic signed [OW-20:0]  wholey_w;
    logic signed [SX_W-1:0] sx_w;
    logic signed [SX_W-1:0] sy_w;
    logic [LIM_W-1:0]       limx_m1;
    logic [LIM_W-1:0]       limy_m1;
    logic [CB-1:0]          src_x_w;
    logic [CB-1:0]          src_y_w;
    logic                   push;
    logic                   pop;
    logic [OUT_TW-1:0]      res_w;

    assign {k_act, k_px, k_negx} = x_side;
    assign {k_py, k_negy}        = y_side;
    assign offx_w   = k_negx ? -$signed({1'b0, x_quo}) : $signed({1'b0, x_quo});
    assign offy_w   = k_negy ? -$signed({1'b0, y_quo}) : $signed({1'b0, y_quo});
    assign wholex_w = offx_w[OW:20];
    assign wholey_w = offy_w[OW:20];
    assign sx_w     = $signed({2'b00, k_px}) + SX_W'(wholex_w);
    assign sy_w     = $signed({2'b00, k_py}) + SX_W'(wholey_w);
    assign limx_m1  = limx - LIM_W'(1);
    assign limy_m1  = limy - LIM_W'(1);

    always_comb
    begin
        if (k_act != rlw_pkg::ACT_COPY || sx_w < 0)
        begin
            src_x_w = '0;
        end
        else if (sx_w >= $signed({1'b0, limx}))
        begin
            src_x_w = limx_m1[CB-1:0];
        end
        else
        begin
            src_x_w = sx_w[CB-1:0];
        end

        if (k_act != rlw_pkg::ACT_COPY || sy_w < 0)
        begin
            src_y_w = '0;
        end
        else if (sy_w >= $signed({1'b0, limy}))
        begin
            src_y_w = limy_m1[CB-1:0];
        end
        else
        begin
            src_y_w = sy_w[CB-1:0];
        end
    end

    assign res_w = OUT_TW'({src_y_w, src_x_w, k_act});
    assign push  = en & x_valid & y_valid;
    assign pop   = out_valid_reg & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res_w;
            end
            else
            begin
                out_data_reg <= res_w;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
